[sv/adaptive_onset_gate_unit_macros.svh]
// assertion macros for the adaptive onset gate unit
// used by the top level only, no other dependencies
`ifndef ADAPTIVE_ONSET_GATE_UNIT_MACROS_SVH
`define ADAPTIVE_ONSET_GATE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define AOG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define AOG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/aog_pkg.sv]
// shared constants, register indexes and control structs for the onset gate
// no dependencies
`default_nettype none

package aog_pkg;

   localparam int WINDOW_DEPTH = 48;
   localparam int IDX_W        = $clog2(WINDOW_DEPTH);
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

   localparam int STR_W        = 31;
   localparam int RAW_STR_W    = 32;
   localparam int TIME_W       = 48;
   localparam int LEVEL_W      = 16;
   localparam int DUP_W        = 20;
   localparam int THR_W        = 32;

   localparam int REQ_TDATA_W  = 144;
   localparam int REQ_TUSER_W  = 3;
   localparam int RSP_TDATA_W  = 80;

   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_GATE_LEVEL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_EXEMPT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_STR     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_FLOOR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DUP_WINDOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_OFFSET = 3'd5;

   typedef struct packed {
      logic             push;
      logic [STR_W-1:0] push_data;
      logic             start;
   } win_ctl_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [STR_W-1:0] median;
   } win_stat_type;

endpackage

`default_nettype wire

[sv/aog_window.sv]
// strength window memory with a rank-counting upper-median sequencer
// depends on aog_pkg
`default_nettype none

module aog_window (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire aog_pkg::win_ctl_type ctl,
   output aog_pkg::win_stat_type     stat
);

   typedef enum logic [2:0] {
      W_IDLE,
      W_CAND,
      W_LOAD,
      W_SCAN,
      W_DECIDE
   } wstate_type;

   wstate_type                     state_ff;
   logic [aog_pkg::IDX_W-1:0]      head_ff;
   logic [aog_pkg::CNT_W-1:0]      count_ff;
   logic [aog_pkg::IDX_W-1:0]      cand_idx_ff;
   logic [aog_pkg::IDX_W-1:0]      scan_idx_ff;
   logic [aog_pkg::STR_W-1:0]      cand_ff;
   logic [aog_pkg::CNT_W-1:0]      less_ff;
   logic [aog_pkg::CNT_W-1:0]      leq_ff;
   logic                           done_ff;
   logic [aog_pkg::STR_W-1:0]      median_ff;
   logic [aog_pkg::STR_W-1:0]      rdata_ff;

   logic [aog_pkg::STR_W-1:0]      mem [aog_pkg::WINDOW_DEPTH];

   logic [aog_pkg::IDX_W-1:0]      rd_addr;
   logic [aog_pkg::IDX_W-1:0]      last_idx;
   logic [aog_pkg::IDX_W-1:0]      head_in;
   logic [aog_pkg::CNT_W-1:0]      rank_k;
   logic [aog_pkg::CNT_W-1:0]      less_in;
   logic [aog_pkg::CNT_W-1:0]      leq_in;
   logic                           hit;
   logic                           done_in;

   // filled entries always sit at indexes 0 .. count-1
   assign last_idx = aog_pkg::IDX_W'(count_ff - aog_pkg::CNT_W'(1));
   assign rank_k   = count_ff >> 1;
   assign head_in  = (head_ff == aog_pkg::IDX_W'(aog_pkg::WINDOW_DEPTH - 1)) ?
                     '0 : head_ff + aog_pkg::IDX_W'(1);
   assign less_in  = less_ff + aog_pkg::CNT_W'(rdata_ff < cand_ff);
   assign leq_in   = leq_ff + aog_pkg::CNT_W'(rdata_ff <= cand_ff);
   assign hit      = (less_ff <= rank_k) && (rank_k < leq_ff);

   // one-cycle done pulse: empty window at start, or the last decision
   assign done_in  = ((state_ff == W_IDLE) && ctl.start && (count_ff == '0)) ||
                     ((state_ff == W_DECIDE) && (hit || cand_idx_ff == last_idx));

   always_comb begin
      case (state_ff)
         W_CAND:  rd_addr = cand_idx_ff;
         W_SCAN:  rd_addr = (scan_idx_ff == last_idx) ? scan_idx_ff :
                            scan_idx_ff + aog_pkg::IDX_W'(1);
         default: rd_addr = '0;
      endcase
   end

   // single write port, single registered read port
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[head_ff] <= ctl.push_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= W_IDLE;
         head_ff   <= '0;
         count_ff  <= '0;
         done_ff   <= 1'b0;
      end else begin
         done_ff <= done_in;
         if (ctl.push) begin
            head_ff <= head_in;
            if (count_ff != aog_pkg::CNT_W'(aog_pkg::WINDOW_DEPTH)) begin
               count_ff <= count_ff + aog_pkg::CNT_W'(1);
            end
         end
         case (state_ff)
            W_IDLE: begin
               if (ctl.start) begin
                  if (count_ff == '0) begin
                     median_ff <= '0;
                  end else begin
                     cand_idx_ff <= '0;
                     state_ff    <= W_CAND;
                  end
               end
            end
            W_CAND: begin
               state_ff <= W_LOAD;
            end
            W_LOAD: begin
               cand_ff     <= rdata_ff;
               less_ff     <= '0;
               leq_ff      <= '0;
               scan_idx_ff <= '0;
               state_ff    <= W_SCAN;
            end
            W_SCAN: begin
               less_ff <= less_in;
               leq_ff  <= leq_in;
               if (scan_idx_ff == last_idx) begin
                  state_ff <= W_DECIDE;
               end else begin
                  scan_idx_ff <= scan_idx_ff + aog_pkg::IDX_W'(1);
               end
            end
            W_DECIDE: begin
               if (hit || cand_idx_ff == last_idx) begin
                  median_ff <= hit ? cand_ff : '0;
                  state_ff  <= W_IDLE;
               end else begin
                  cand_idx_ff <= cand_idx_ff + aog_pkg::IDX_W'(1);
                  state_ff    <= W_CAND;
               end
            end
            default: state_ff <= W_IDLE;
         endcase
      end
   end

   assign stat.busy   = (state_ff != W_IDLE);
   assign stat.done   = done_ff;
   assign stat.median = median_ff;

endmodule

`default_nettype wire

[sv/adaptive_onset_gate_unit.sv]
// adaptive onset gate: level gate, adaptive median threshold, duplicate suppression
// depends on aog_pkg, aog_window and adaptive_onset_gate_unit_macros.svh
//
//   channel | dir | handshake           | payload
//   req_    | in  | req_tvalid/tready   | tdata: strength, reported_time, hop_time,
//           |     |                     |        audio_level; tuser: three flags
//   rsp_    | out | rsp_tvalid/tready   | tdata: onset_time, onset_strength
//   csr_    | in  | csr_valid/ready     | csr_index, csr_data
//
// an item without an onset, or one rejected early, goes back to idle from the check state
// an onset that passes the early checks waits for the median of the window (fill up to
// 48 entries): the rank scan reads one window entry per cycle from the single read port
// of the window memory
// reset is synchronous; window contents are not cleared, the fill count hides them
// a waiting result does not block the next transfer on req_; a new result waits
// in the emit state until the output register is free
`default_nettype none
`include "adaptive_onset_gate_unit_macros.svh"

module adaptive_onset_gate_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // strength[31:0], reported_time[79:32], hop_time[127:80], audio_level[143:128]
   input  wire logic [aog_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // strength_valid[0], onset_flag[1], reported_valid[2]
   input  wire logic [aog_pkg::REQ_TUSER_W-1:0]      req_tuser,
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   // onset_time[47:0], onset_strength[78:48], zero pad[79]
   output      logic [aog_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [aog_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [aog_pkg::CSR_DATA_W-1:0]       csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_MEDIAN,
      S_THRESH,
      S_EMIT
   } state_type;

   // configuration registers
   logic [aog_pkg::LEVEL_W-1:0]  gate_level_ff;
   logic                         gate_exempt_ff;
   logic [aog_pkg::THR_W-1:0]    min_strength_ff;
   logic [aog_pkg::THR_W-1:0]    cal_floor_ff;
   logic [aog_pkg::DUP_W-1:0]    dup_window_ff;
   logic [aog_pkg::TIME_W-1:0]   time_offset_ff;

   // item being worked on
   state_type                    state_ff;
   logic [aog_pkg::STR_W-1:0]    str_ff;
   logic                         str_ok_ff;
   logic                         onset_ff;
   logic                         rvalid_ff;
   logic [aog_pkg::TIME_W-1:0]   rtime_ff;
   logic [aog_pkg::TIME_W-1:0]   htime_ff;
   logic [aog_pkg::LEVEL_W-1:0]  level_ff;
   logic [aog_pkg::TIME_W-1:0]   time_ff;
   logic [aog_pkg::STR_W-1:0]    median_ff;

   // onset history and output register
   logic [aog_pkg::TIME_W-1:0]   last_time_ff;
   logic                         last_valid_ff;
   logic                         rsp_tvalid_ff;
   logic [aog_pkg::TIME_W-1:0]   rsp_time_ff;
   logic [aog_pkg::STR_W-1:0]    rsp_str_ff;

   aog_pkg::win_ctl_type         win_ctl;
   aog_pkg::win_stat_type        win_stat;

   logic                         req_xfer;
   logic                         raw_negative;
   logic [aog_pkg::TIME_W:0]     time_sum;
   logic [aog_pkg::TIME_W-1:0]   time_in;
   logic                         pass_early;
   logic                         too_weak;
   logic                         dup_hit;
   logic                         out_free;

   assign req_tready   = (state_ff == S_IDLE);
   assign req_xfer     = req_tvalid && req_tready;
   assign raw_negative = req_tdata[aog_pkg::RAW_STR_W-1];
   assign csr_ready    = 1'b1;

   // valid, non-negative strength enters the window at the input transfer
   assign win_ctl.push      = req_xfer && req_tuser[0] && !raw_negative;
   assign win_ctl.push_data = req_tdata[aog_pkg::STR_W-1:0];
   assign win_ctl.start     = (state_ff == S_CHECK) && pass_early;

   aog_window u_window (
      .clock (clock),
      .reset (reset),
      .ctl   (win_ctl),
      .stat  (win_stat)
   );

   // onset time: reported time plus offset, saturating, else hop time
   assign time_sum = {1'b0, rtime_ff} + {1'b0, time_offset_ff};
   assign time_in  = !rvalid_ff ? htime_ff :
                     time_sum[aog_pkg::TIME_W] ? '1 : time_sum[aog_pkg::TIME_W-1:0];

   // onset flag, level gate, strength validity and the two fixed floors
   assign pass_early = onset_ff && str_ok_ff &&
                       (gate_exempt_ff || level_ff >= gate_level_ff) &&
                       ({1'b0, str_ff} >= min_strength_ff) &&
                       ({1'b0, str_ff} >= cal_floor_ff);

   // 2 x strength against 5 x median, exact
   assign too_weak = {2'b00, str_ff, 1'b0} <
                     ({1'b0, median_ff, 2'b00} + {3'b000, median_ff});

   // earlier than last accepted onset counts as a duplicate too
   assign dup_hit = last_valid_ff &&
                    ({1'b0, time_ff} <
                     ({1'b0, last_time_ff} +
                      {{(aog_pkg::TIME_W + 1 - aog_pkg::DUP_W){1'b0}}, dup_window_ff}));

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // configuration writes, out-of-range indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_level_ff   <= '0;
         gate_exempt_ff  <= 1'b0;
         min_strength_ff <= '0;
         cal_floor_ff    <= '0;
         dup_window_ff   <= '0;
         time_offset_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            aog_pkg::CSR_GATE_LEVEL:  gate_level_ff   <= csr_data[aog_pkg::LEVEL_W-1:0];
            aog_pkg::CSR_GATE_EXEMPT: gate_exempt_ff  <= csr_data[0];
            aog_pkg::CSR_MIN_STR:     min_strength_ff <= csr_data[aog_pkg::THR_W-1:0];
            aog_pkg::CSR_CAL_FLOOR:   cal_floor_ff    <= csr_data[aog_pkg::THR_W-1:0];
            aog_pkg::CSR_DUP_WINDOW:  dup_window_ff   <= csr_data[aog_pkg::DUP_W-1:0];
            aog_pkg::CSR_TIME_OFFSET: time_offset_ff  <= csr_data[aog_pkg::TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // main sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_time_ff  <= '0;
         last_valid_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // the emit state reloads the output register itself
         if (rsp_tvalid_ff && rsp_tready && state_ff != S_EMIT) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  str_ff    <= req_tdata[aog_pkg::STR_W-1:0];
                  str_ok_ff <= req_tuser[0] && !raw_negative;
                  onset_ff  <= req_tuser[1];
                  rvalid_ff <= req_tuser[2];
                  rtime_ff  <= req_tdata[79:32];
                  htime_ff  <= req_tdata[127:80];
                  level_ff  <= req_tdata[143:128];
                  state_ff  <= S_CHECK;
               end
            end
            S_CHECK: begin
               time_ff  <= time_in;
               state_ff <= pass_early ? S_MEDIAN : S_IDLE;
            end
            S_MEDIAN: begin
               if (win_stat.done) begin
                  median_ff <= win_stat.median;
                  state_ff  <= S_THRESH;
               end
            end
            S_THRESH: begin
               if (too_weak || dup_hit) begin
                  state_ff <= S_IDLE;
               end else begin
                  last_time_ff  <= time_ff;
                  last_valid_ff <= 1'b1;
                  state_ff      <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_time_ff   <= time_ff;
                  rsp_str_ff    <= str_ff;
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(aog_pkg::RSP_TDATA_W - aog_pkg::TIME_W - aog_pkg::STR_W){1'b0}},
                        rsp_str_ff, rsp_time_ff};

   // window sequencer is never mid-scan when a new item comes in
   `AOG_ASSERT_NOW(a_accept_win_idle, clock, reset, req_xfer, !win_stat.busy, "transfer while window busy")
   // a median result only arrives while the sequencer waits for it
   `AOG_ASSERT_NOW(a_done_in_median, clock, reset, win_stat.done, state_ff == S_MEDIAN, "median done out of turn")
   // once an onset is accepted the history stays valid
   `AOG_ASSERT_NEXT(a_last_valid_holds, clock, reset, last_valid_ff, last_valid_ff, "onset history lost")
   // a fresh result (rising valid) is checked against both fixed floors as they stand then
   `AOG_ASSERT_NOW(a_result_floor, clock, reset, $rose(rsp_tvalid_ff), ({1'b0, rsp_str_ff} >= min_strength_ff) && ({1'b0, rsp_str_ff} >= cal_floor_ff), "result below floor")

endmodule

`default_nettype wire
